// File: hdl/gvqa_pkg.sv
// Shared types, constants and the GLL weight table for the volume quadrature accumulator.
// No dependencies; every other file but gvqa_fifo refers to it by scoped names.
`timescale 1ns / 1ps

package gvqa_pkg;

  // Spectral order limits and register widths
  localparam logic [3:0] MIN_ORDER = 4'd2;
  localparam logic [3:0] MAX_ORDER = 4'd10;
  localparam int ORDER_W  = 4;
  localparam int WEIGHT_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_ORDER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMP_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_SCALE = 2'd2;

  // Fixed-point formats
  localparam int ACC_W      = 64;  // Q39.24 accumulator
  localparam int TERM_W     = 58;  // magnitude of one weighted term
  localparam int MAG_PAD_W  = 48;  // widest sample magnitude
  localparam int OUT_W      = 48;  // Q31.16 result
  localparam int COMP_OUT_W = 3;
  localparam int WPROD_SHIFT    = 30;
  localparam int ACC_FRAC_SHIFT = 22;
  localparam int SCALE_SHIFT    = 24;

  // Depth of the queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;

  // Per-axis GLL weights in Q1.30, first half of each row (rows are symmetric)
  localparam logic [WEIGHT_W-1:0] GLL_HALF [0:8][0:5] = '{
    '{32'd357913941, 32'd1431655765, 32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd178956971, 32'd894784853, 32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd107374182, 32'd584592771, 32'd763549742, 32'd0, 32'd0, 32'd0},
    '{32'd71582788, 32'd406384390, 32'd595774646, 32'd0, 32'd0, 32'd0},
    '{32'd51130563, 32'd297239705, 32'd463583073, 32'd523576966, 32'd0, 32'd0},
    '{32'd38347922, 32'd226241941, 32'd366277702, 32'd442874259, 32'd0, 32'd0},
    '{32'd29826162, 32'd177699291, 32'd294783698, 32'd371974781, 32'd398915783,
      32'd0},
    '{32'd23860929, 32'd143136218, 32'd241473092, 32'd313578444, 32'd351693141,
      32'd0},
    '{32'd19522579, 32'd117695282, 32'd200972130, 32'd266339624, 32'd308034115,
      32'd322356189}
  };

  // Control bits carried with a sample through front, queue and back
  typedef struct packed {
    logic neg;
    logic last;
  } job_flags_t;

  // Control bits carried with an accumulator through the scaling pipeline
  typedef struct packed {
    logic neg;
    logic sat;
    logic last;
  } res_flags_t;

  // Weight of point idx on one axis; order already clamped, idx within 0..order
  function automatic logic [WEIGHT_W-1:0] axis_weight(input logic [ORDER_W-1:0] order,
                                                      input logic [ORDER_W-1:0] idx);
    logic [ORDER_W-1:0] mirror;
    logic [ORDER_W-1:0] sel;
    logic [ORDER_W-1:0] row;
    mirror = order - idx;
    sel    = (mirror < idx) ? mirror : idx;
    row    = order - MIN_ORDER;
    return GLL_HALF[row][sel[2:0]];
  endfunction

endpackage

// File: hdl/gll_volume_quadrature_accumulator.sv
// Top level of the GLL volume quadrature accumulator: configuration registers, front part,
// queue, back part and scaling pipeline. Depends on gvqa_pkg and all gvqa_* modules.
`timescale 1ns / 1ps

// Samples of a field over hexahedral spectral elements stream in component fastest, then
// point i, j, k, element by element. Each is weighted by the product of three GLL weights
// for the configured order and added, saturating, to its component's accumulator. One
// sample is taken every clock cycle, sustained, unless sample_stall is raised; the rate is
// set by the single read-modify-write of the accumulator bank, and a sample reaches it
// through three front stages, the queue and two term stages. The sample marked last
// moves all accumulators into a snapshot bank and clears them, so the next run may start at
// once; the snapshot is then read out one component a cycle, unless the scaler stalls, into
// a three-stage scaling pipeline, giving component_count results. A further last sample
// waits in the back part until the previous read-out has left the snapshot bank.
// Configuration is written through a port that is always ready and must only change
// while the block is idle.
module gll_volume_quadrature_accumulator #(
  parameter int MAX_COMPONENTS = 8,
  parameter int SAMPLE_WIDTH   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gvqa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gvqa_pkg::CFG_DATA_W-1:0]      cfg_data,
  // sample stream
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_value,
  input  logic                                 last_sample,
  // result stream
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [gvqa_pkg::COMP_OUT_W-1:0]      comp_index,
  output logic signed [gvqa_pkg::OUT_W-1:0]    integral_value,
  output logic                                 saturated,
  output logic                                 last_result
);

  localparam int CW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);
  localparam int OW    = gvqa_pkg::ORDER_W;
  localparam int WW    = gvqa_pkg::WEIGHT_W;
  localparam int FW    = $bits(gvqa_pkg::job_flags_t);
  localparam int JW    = SAMPLE_WIDTH + WW + CW + FW;

  // Configuration registers
  logic [OW-1:0]                     quad_order;
  logic [OW-1:0]                     component_count;
  logic [gvqa_pkg::CFG_DATA_W-1:0]   volume_scale;

  logic [OW-1:0]    order_eff;
  logic [CNT_W-1:0] comp_limit;

  // Front to queue
  logic                 fr_valid, fr_ready;
  logic [SAMPLE_WIDTH-1:0] fr_mag;
  logic [WW-1:0]        fr_weight;
  logic [CW-1:0]        fr_comp;
  gvqa_pkg::job_flags_t fr_flags;
  logic                 smp_ready;

  // Queue to back
  logic                 bk_valid, bk_ready;
  logic [JW-1:0]        bk_data;
  logic [SAMPLE_WIDTH-1:0] bk_mag;
  logic [WW-1:0]        bk_weight;
  logic [CW-1:0]        bk_comp;
  gvqa_pkg::job_flags_t bk_flags;

  // Back to scaler
  logic                 drn_valid, drn_ready;
  logic [gvqa_pkg::ACC_W-1:0] drn_mag;
  logic [CW-1:0]        drn_comp;
  gvqa_pkg::res_flags_t drn_flags;

  assign cfg_ready    = 1'b1;
  assign sample_stall = !smp_ready;

  // Register writes; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_order      <= gvqa_pkg::MIN_ORDER;
      component_count <= OW'(1);
      volume_scale    <= gvqa_pkg::CFG_DATA_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gvqa_pkg::CFG_QUAD_ORDER:   quad_order      <= cfg_data[OW-1:0];
        gvqa_pkg::CFG_COMP_COUNT:   component_count <= cfg_data[OW-1:0];
        gvqa_pkg::CFG_VOLUME_SCALE: volume_scale    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Out-of-range order and component count are clamped into range
  always_comb begin
    if (quad_order < gvqa_pkg::MIN_ORDER) begin
      order_eff = gvqa_pkg::MIN_ORDER;
    end else if (quad_order > gvqa_pkg::MAX_ORDER) begin
      order_eff = gvqa_pkg::MAX_ORDER;
    end else begin
      order_eff = quad_order;
    end
    if (component_count == '0) begin
      comp_limit = CNT_W'(1);
    end else if (32'(component_count) > 32'(MAX_COMPONENTS)) begin
      comp_limit = CNT_W'(MAX_COMPONENTS);
    end else begin
      comp_limit = CNT_W'(component_count);
    end
  end

  gvqa_front #(
    .MAX_COMPONENTS(MAX_COMPONENTS),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .order_eff (order_eff),
    .comp_limit(comp_limit),
    .smp_valid (sample_valid),
    .smp_ready (smp_ready),
    .smp_value (sample_value),
    .smp_last  (last_sample),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job_mag   (fr_mag),
    .job_weight(fr_weight),
    .job_comp  (fr_comp),
    .job_flags (fr_flags)
  );

  gvqa_fifo #(
    .WIDTH(JW),
    .DEPTH(gvqa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_data ({fr_mag, fr_weight, fr_comp, fr_flags}),
    .pop_valid (bk_valid),
    .pop_ready (bk_ready),
    .pop_data  (bk_data)
  );

  assign {bk_mag, bk_weight, bk_comp, bk_flags} = bk_data;

  gvqa_back #(
    .MAX_COMPONENTS(MAX_COMPONENTS),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .comp_limit(comp_limit),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job_mag   (bk_mag),
    .job_weight(bk_weight),
    .job_comp  (bk_comp),
    .job_flags (bk_flags),
    .drn_valid (drn_valid),
    .drn_ready (drn_ready),
    .drn_mag   (drn_mag),
    .drn_comp  (drn_comp),
    .drn_flags (drn_flags)
  );

  gvqa_scale #(
    .MAX_COMPONENTS(MAX_COMPONENTS)
  ) u_scale (
    .clk           (clk),
    .rst           (rst),
    .volume_scale  (volume_scale),
    .drn_valid     (drn_valid),
    .drn_ready     (drn_ready),
    .drn_mag       (drn_mag),
    .drn_comp      (drn_comp),
    .drn_flags     (drn_flags),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .comp_index    (comp_index),
    .integral_value(integral_value),
    .saturated     (saturated),
    .last_result   (last_result)
  );

endmodule

// File: hdl/gvqa_front.sv
// Front part: takes samples, runs the point counters and forms the Q2.30 weight product.
// Depends on gvqa_pkg (weight table, flag struct).
`timescale 1ns / 1ps

module gvqa_front #(
  parameter int MAX_COMPONENTS = 8,
  parameter int SAMPLE_WIDTH   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [gvqa_pkg::ORDER_W-1:0]          order_eff,
  input  logic [$clog2(MAX_COMPONENTS+1)-1:0]   comp_limit,
  input  logic                                  smp_valid,
  output logic                                  smp_ready,
  input  logic [SAMPLE_WIDTH-1:0]               smp_value,
  input  logic                                  smp_last,
  output logic                                  job_valid,
  input  logic                                  job_ready,
  output logic [SAMPLE_WIDTH-1:0]               job_mag,
  output logic [gvqa_pkg::WEIGHT_W-1:0]         job_weight,
  output logic [((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)-1:0] job_comp,
  output gvqa_pkg::job_flags_t                  job_flags
);

  localparam int CW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);
  localparam int OW    = gvqa_pkg::ORDER_W;
  localparam int WW    = gvqa_pkg::WEIGHT_W;
  localparam logic [2*WW-1:0] WROUND = (2*WW)'(1) << (gvqa_pkg::WPROD_SHIFT - 1);

  // Point counters
  logic [CW-1:0] comp_cnt, comp_cnt_next;
  logic [OW-1:0] i_cnt, i_cnt_next;
  logic [OW-1:0] j_cnt, j_cnt_next;
  logic [OW-1:0] k_cnt, k_cnt_next;
  logic [CW-1:0] comp_eff;
  logic [OW-1:0] i_eff, j_eff, k_eff;
  logic          comp_wrap, i_wrap, j_wrap, k_wrap;
  logic          take;

  // Stage 0: looked-up axis weights
  logic                 v0;
  logic [WW-1:0]        wi0, wj0, wk0;
  logic [SAMPLE_WIDTH-1:0] mag0;
  logic [CW-1:0]        comp0;
  gvqa_pkg::job_flags_t flags0;

  // Stage 1: product of the i and j weights
  logic                 v1;
  logic [WW-1:0]        pij1, wk1;
  logic [SAMPLE_WIDTH-1:0] mag1;
  logic [CW-1:0]        comp1;
  gvqa_pkg::job_flags_t flags1;
  logic [2*WW-1:0]      prod_ij;

  // Stage 2 is the job register itself
  logic [2*WW-1:0]      prod_ijk;
  logic                 ready0, ready1, ready2;

  assign ready2    = !job_valid || job_ready;
  assign ready1    = !v1 || ready2;
  assign ready0    = !v0 || ready1;
  assign smp_ready = ready0;
  assign take      = smp_valid && ready0;

  // A counter past its bound counts as zero
  always_comb begin
    comp_eff  = (CNT_W'(comp_cnt) >= comp_limit) ? '0 : comp_cnt;
    i_eff     = (i_cnt > order_eff) ? '0 : i_cnt;
    j_eff     = (j_cnt > order_eff) ? '0 : j_cnt;
    k_eff     = (k_cnt > order_eff) ? '0 : k_cnt;
    comp_wrap = (CNT_W'(comp_eff) + CNT_W'(1)) == comp_limit;
    i_wrap    = i_eff == order_eff;
    j_wrap    = j_eff == order_eff;
    k_wrap    = k_eff == order_eff;
  end

  // Next counter values: component fastest, then i, j, k; cleared after the last sample
  always_comb begin
    comp_cnt_next = comp_wrap ? '0 : comp_eff + CW'(1);
    i_cnt_next    = i_eff;
    j_cnt_next    = j_eff;
    k_cnt_next    = k_eff;
    if (comp_wrap) begin
      i_cnt_next = i_wrap ? '0 : i_eff + OW'(1);
      if (i_wrap) begin
        j_cnt_next = j_wrap ? '0 : j_eff + OW'(1);
        if (j_wrap) begin
          k_cnt_next = k_wrap ? '0 : k_eff + OW'(1);
        end
      end
    end
    if (smp_last) begin
      comp_cnt_next = '0;
      i_cnt_next    = '0;
      j_cnt_next    = '0;
      k_cnt_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_cnt <= '0;
      i_cnt    <= '0;
      j_cnt    <= '0;
      k_cnt    <= '0;
    end else if (take) begin
      comp_cnt <= comp_cnt_next;
      i_cnt    <= i_cnt_next;
      j_cnt    <= j_cnt_next;
      k_cnt    <= k_cnt_next;
    end
  end

  // Stage 0: weight lookup and sample magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ready0) begin
      v0 <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wi0         <= gvqa_pkg::axis_weight(order_eff, i_eff);
      wj0         <= gvqa_pkg::axis_weight(order_eff, j_eff);
      wk0         <= gvqa_pkg::axis_weight(order_eff, k_eff);
      mag0        <= smp_value[SAMPLE_WIDTH-1] ? (~smp_value + SAMPLE_WIDTH'(1)) : smp_value;
      comp0       <= comp_eff;
      flags0.neg  <= smp_value[SAMPLE_WIDTH-1];
      flags0.last <= smp_last;
    end
  end

  // Stage 1: w_i * w_j, rounded back to Q.30
  assign prod_ij = (2*WW)'(wi0) * (2*WW)'(wj0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && v0) begin
      pij1   <= WW'((prod_ij + WROUND) >> gvqa_pkg::WPROD_SHIFT);
      wk1    <= wk0;
      mag1   <= mag0;
      comp1  <= comp0;
      flags1 <= flags0;
    end
  end

  // Stage 2: times w_k, rounded to the Q2.30 product
  assign prod_ijk = (2*WW)'(pij1) * (2*WW)'(wk1);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (ready2) begin
      job_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      job_weight <= WW'((prod_ijk + WROUND) >> gvqa_pkg::WPROD_SHIFT);
      job_mag    <= mag1;
      job_comp   <= comp1;
      job_flags  <= flags1;
    end
  end

endmodule

// File: hdl/gvqa_fifo.sv
// Short queue between the front and back parts, so each side stalls on its own.
// Depends on nothing outside itself.
`timescale 1ns / 1ps

module gvqa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    fill;
  logic             push, pop;

  assign push_ready = fill != NW'(DEPTH);
  assign pop_valid  = fill != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

// File: hdl/gvqa_back.sv
// Back part: weighted term, saturating accumulation per component, end-of-run snapshot
// and the serial read-out of the snapshot towards the scaler. Depends on gvqa_pkg.
`timescale 1ns / 1ps

module gvqa_back #(
  parameter int MAX_COMPONENTS = 8,
  parameter int SAMPLE_WIDTH   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [$clog2(MAX_COMPONENTS+1)-1:0]   comp_limit,
  input  logic                                  job_valid,
  output logic                                  job_ready,
  input  logic [SAMPLE_WIDTH-1:0]               job_mag,
  input  logic [gvqa_pkg::WEIGHT_W-1:0]         job_weight,
  input  logic [((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)-1:0] job_comp,
  input  gvqa_pkg::job_flags_t                  job_flags,
  output logic                                  drn_valid,
  input  logic                                  drn_ready,
  output logic [gvqa_pkg::ACC_W-1:0]            drn_mag,
  output logic [((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)-1:0] drn_comp,
  output gvqa_pkg::res_flags_t                  drn_flags
);

  localparam int CW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);
  localparam int WW    = gvqa_pkg::WEIGHT_W;
  localparam int AW    = gvqa_pkg::ACC_W;
  localparam int TW    = gvqa_pkg::TERM_W;
  localparam int MW    = gvqa_pkg::MAG_PAD_W;
  localparam int PW    = MW + WW;
  localparam logic [PW-1:0] TROUND = PW'(1) << (gvqa_pkg::ACC_FRAC_SHIFT - 1);
  localparam logic [AW-1:0] POS_CAP = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] NEG_CAP = {1'b1, {(AW-1){1'b0}}};

  // Stage 1: partial products of magnitude and weight
  logic                 vb1;
  logic [2*WW-1:0]      plo;
  logic [MW-WW+WW-1:0]  phi;
  logic [CW-1:0]        comp1;
  gvqa_pkg::job_flags_t flags1;
  logic [MW-1:0]        mag_pad;

  // Stage 2: rounded term, ready to accumulate
  logic                 vb2;
  logic [TW-1:0]        term2;
  logic [CW-1:0]        comp2;
  gvqa_pkg::job_flags_t flags2;
  logic [PW-1:0]        prod;

  // Working accumulators and the snapshot taken at the end of a run
  logic [AW-1:0]             acc  [MAX_COMPONENTS];
  logic [MAX_COMPONENTS-1:0] acc_sat;
  logic [AW-1:0]             snap [MAX_COMPONENTS];
  logic [MAX_COMPONENTS-1:0] snap_sat;
  logic                      busy;
  logic [CW-1:0]             drn_idx;
  logic [CNT_W-1:0]          drn_count;

  logic          ready_b1, ready_b2, ready_d, commit, drn_last, drn_take;
  logic [AW-1:0] acc_old, acc_sum, acc_new, snap_word;
  logic          ovf;

  assign ready_d   = !drn_valid || drn_ready;
  assign commit    = vb2 && !(flags2.last && busy);
  assign ready_b2  = !vb2 || commit;
  assign ready_b1  = !vb1 || ready_b2;
  assign job_ready = ready_b1;

  // Stage 1: split the magnitude so each multiplier stays 32 bits wide
  assign mag_pad = MW'(job_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb1 <= 1'b0;
    end else if (ready_b1) begin
      vb1 <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b1 && job_valid) begin
      plo    <= (2*WW)'(mag_pad[WW-1:0]) * (2*WW)'(job_weight);
      phi    <= MW'(mag_pad[MW-1:WW]) * MW'(job_weight);
      comp1  <= job_comp;
      flags1 <= job_flags;
    end
  end

  // Stage 2: join the partials and round half up to Q.24
  assign prod = {phi, {WW{1'b0}}} + PW'(plo);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb2 <= 1'b0;
    end else if (ready_b2) begin
      vb2 <= vb1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b2 && vb1) begin
      term2  <= TW'((prod + TROUND) >> gvqa_pkg::ACC_FRAC_SHIFT);
      comp2  <= comp1;
      flags2 <= flags1;
    end
  end

  // Saturating add or subtract of the term; the term itself is never negative
  always_comb begin
    acc_old = acc[comp2];
    acc_sum = flags2.neg ? acc_old - AW'(term2) : acc_old + AW'(term2);
    ovf     = flags2.neg ? (acc_old[AW-1] && !acc_sum[AW-1])
                         : (!acc_old[AW-1] && acc_sum[AW-1]);
    acc_new = acc_sum;
    if (ovf) begin
      acc_new = flags2.neg ? NEG_CAP : POS_CAP;
    end
  end

  // Accumulators: updated per term, moved to the snapshot and cleared on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < MAX_COMPONENTS; c++) begin
        acc[c] <= '0;
      end
      acc_sat <= '0;
    end else if (commit) begin
      if (flags2.last) begin
        for (int c = 0; c < MAX_COMPONENTS; c++) begin
          acc[c] <= '0;
        end
        acc_sat <= '0;
      end else begin
        acc[comp2]     <= acc_new;
        acc_sat[comp2] <= acc_sat[comp2] | ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && flags2.last) begin
      for (int c = 0; c < MAX_COMPONENTS; c++) begin
        if (CW'(c) == comp2) begin
          snap[c]     <= acc_new;
          snap_sat[c] <= acc_sat[c] | ovf;
        end else begin
          snap[c]     <= acc[c];
          snap_sat[c] <= acc_sat[c];
        end
      end
    end
  end

  // Read-out of the snapshot, one component a cycle while the scaler is ready
  assign drn_take  = busy && ready_d;
  assign drn_last  = (CNT_W'(drn_idx) + CNT_W'(1)) == drn_count;
  assign snap_word = snap[drn_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      drn_idx   <= '0;
      drn_count <= '0;
      drn_valid <= 1'b0;
    end else begin
      if (commit && flags2.last) begin
        busy      <= 1'b1;
        drn_idx   <= '0;
        drn_count <= comp_limit;
      end else if (drn_take) begin
        drn_idx <= drn_idx + CW'(1);
        if (drn_last) begin
          busy <= 1'b0;
        end
      end
      if (ready_d) begin
        drn_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drn_take) begin
      drn_mag        <= snap_word[AW-1] ? (~snap_word + AW'(1)) : snap_word;
      drn_comp       <= drn_idx;
      drn_flags.neg  <= snap_word[AW-1];
      drn_flags.sat  <= snap_sat[drn_idx];
      drn_flags.last <= drn_last;
    end
  end

endmodule

// File: hdl/gvqa_scale.sv
// Scaling pipeline: accumulator magnitude times the volume factor, rounding to Q31.16,
// saturation, sign restore and the result register. Depends on gvqa_pkg.
`timescale 1ns / 1ps

module gvqa_scale #(
  parameter int MAX_COMPONENTS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [gvqa_pkg::CFG_DATA_W-1:0]      volume_scale,
  input  logic                                 drn_valid,
  output logic                                 drn_ready,
  input  logic [gvqa_pkg::ACC_W-1:0]           drn_mag,
  input  logic [((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)-1:0] drn_comp,
  input  gvqa_pkg::res_flags_t                 drn_flags,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [gvqa_pkg::COMP_OUT_W-1:0]      comp_index,
  output logic signed [gvqa_pkg::OUT_W-1:0]    integral_value,
  output logic                                 saturated,
  output logic                                 last_result
);

  localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int HW = gvqa_pkg::ACC_W / 2;
  localparam int SH = gvqa_pkg::SCALE_SHIFT;
  localparam int QW = gvqa_pkg::ACC_W + (gvqa_pkg::CFG_DATA_W - SH);
  localparam int OW = gvqa_pkg::OUT_W;
  localparam logic [2*HW-1:0] SROUND  = (2*HW)'(1) << (SH - 1);
  localparam logic [QW-1:0]   POS_CAP = QW'({1'b0, {(OW-1){1'b1}}});
  localparam logic [QW-1:0]   NEG_CAP = QW'({1'b1, {(OW-1){1'b0}}});

  // Stage 1: two 32x32 partial products
  logic                 v1;
  logic [2*HW-1:0]      mlo, mhi;
  logic [CW-1:0]        comp1;
  gvqa_pkg::res_flags_t flags1;

  // Stage 2: unsaturated rounded magnitude
  logic                 v2;
  logic [QW-1:0]        q2;
  logic [CW-1:0]        comp2;
  gvqa_pkg::res_flags_t flags2;

  logic          ready1, ready2, ready3;
  logic [QW-1:0] cap;
  logic          over;
  logic [OW-1:0] clamped;

  assign ready3    = !result_valid || !result_stall;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign drn_ready = ready1;

  // Stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= drn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && drn_valid) begin
      mlo    <= (2*HW)'(drn_mag[HW-1:0]) * (2*HW)'(volume_scale);
      mhi    <= (2*HW)'(drn_mag[2*HW-1:HW]) * (2*HW)'(volume_scale);
      comp1  <= drn_comp;
      flags1 <= drn_flags;
    end
  end

  // Stage 2: high partial lines up 8 bits above the rounded low partial
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      q2     <= {mhi, {(HW - SH){1'b0}}} + QW'((mlo + SROUND) >> SH);
      comp2  <= comp1;
      flags2 <= flags1;
    end
  end

  // Saturation to the signed 48-bit range, asymmetric for the two signs
  always_comb begin
    cap     = flags2.neg ? NEG_CAP : POS_CAP;
    over    = q2 > cap;
    clamped = over ? cap[OW-1:0] : q2[OW-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready3) begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      integral_value <= flags2.neg ? -$signed(clamped) : $signed(clamped);
      saturated      <= flags2.sat | over;
      last_result    <= flags2.last;
      comp_index     <= gvqa_pkg::COMP_OUT_W'(comp2);
    end
  end

endmodule

// File: sim/tb_gll_volume_quadrature_accumulator.sv
// Self-checking testbench for gll_volume_quadrature_accumulator: streams quadrature samples,
// predicts every per-component integral in a scoreboard class and compares each transfer.
// Depends on gvqa_pkg (register indexes, widths, GLL weight table) and the block's RTL.
`timescale 1ns / 1ps

module tb_gll_volume_quadrature_accumulator;

  localparam int unsigned ITEM_TARGET  = 420;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned QUIET_TAIL   = 60;

  localparam logic [gvqa_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [63:0] ROUND30     = 64'h0000_0000_2000_0000;
  localparam logic [63:0] ACC_POS_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ACC_NEG_CAP = 64'h8000_0000_0000_0000;
  localparam logic [63:0] OUT_POS_CAP = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] OUT_NEG_CAP = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [gvqa_pkg::COMP_OUT_W-1:0] comp;
    logic [gvqa_pkg::OUT_W-1:0]      value;
    logic                            sat;
    logic                            last;
  } integral_t;

  // Scoreboard: own copy of registers, accumulators and point counters
  class integral_scoreboard;
    logic [3:0]  quad_order;
    logic [3:0]  comp_count;
    logic [31:0] vol_scale;
    logic [63:0] acc [8];
    bit          acc_sat [8];
    int unsigned comp_pos, pt_i, pt_j, pt_k;
    integral_t   pending_integrals [$];
    int unsigned errors, checked, saw_sat, predicted;

    function new();
      quad_order = gvqa_pkg::MIN_ORDER;
      comp_count = 4'd1;
      vol_scale  = 32'h0001_0000;
      clear_run();
    endfunction

    function void clear_run();
      for (int c = 0; c < 8; c++) begin
        acc[c]     = '0;
        acc_sat[c] = 1'b0;
      end
      comp_pos = 0;
      pt_i     = 0;
      pt_j     = 0;
      pt_k     = 0;
    endfunction

    function void set_reg(logic [gvqa_pkg::CFG_IDX_W-1:0] idx,
                          logic [gvqa_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        gvqa_pkg::CFG_QUAD_ORDER:   quad_order = data[3:0];
        gvqa_pkg::CFG_COMP_COUNT:   comp_count = data[3:0];
        gvqa_pkg::CFG_VOLUME_SCALE: vol_scale  = data;
        default: ;
      endcase
    endfunction

    // Per-axis weight, mirrored about the middle point
    function logic [31:0] point_weight(int unsigned ord, int unsigned idx);
      int unsigned mirror;
      mirror = ord - idx;
      if (mirror < idx) idx = mirror;
      return gvqa_pkg::GLL_HALF[ord - gvqa_pkg::MIN_ORDER][idx];
    endfunction

    // (m * k) >> sh rounded half up, capped; hit marks the cap
    function logic [63:0] mul_round_sat(logic [63:0] m, logic [31:0] k, int unsigned sh,
                                        logic [63:0] cap, output bit hit);
      logic [95:0] prod;
      prod = {32'd0, m} * {64'd0, k};
      prod = (prod + (96'd1 << (sh - 1))) >> sh;
      hit  = (prod > {32'd0, cap});
      return hit ? cap : prod[63:0];
    endfunction

    // Accepted sample: accumulate, and on the last mark queue one integral per component
    function void take_sample(logic [31:0] v, bit is_last);
      int unsigned ord, cc;
      logic [31:0] mag;
      logic [63:0] wprod, term, sum, a, r;
      bit          hit;
      integral_t   want;
      ord = 32'(quad_order);
      if (ord < gvqa_pkg::MIN_ORDER) ord = 32'(gvqa_pkg::MIN_ORDER);
      if (ord > gvqa_pkg::MAX_ORDER) ord = 32'(gvqa_pkg::MAX_ORDER);
      cc = 32'(comp_count);
      if (cc == 0) cc = 1;
      if (cc > 8) cc = 8;
      // counters left beyond a reduced bound restart at zero
      if (comp_pos >= cc) comp_pos = 0;
      if (pt_i > ord) pt_i = 0;
      if (pt_j > ord) pt_j = 0;
      if (pt_k > ord) pt_k = 0;

      wprod = ({32'd0, point_weight(ord, pt_i)} * {32'd0, point_weight(ord, pt_j)}
               + ROUND30) >> 30;
      wprod = (wprod * {32'd0, point_weight(ord, pt_k)} + ROUND30) >> 30;

      mag  = v[31] ? -v : v;
      term = mul_round_sat({32'd0, mag}, wprod[31:0], gvqa_pkg::ACC_FRAC_SHIFT,
                           ACC_POS_CAP, hit);
      if (v[31]) term = -term;
      sum = acc[comp_pos] + term;
      if (acc[comp_pos][63] == term[63] && sum[63] != term[63]) begin
        acc_sat[comp_pos] = 1'b1;
        sum = term[63] ? ACC_NEG_CAP : ACC_POS_CAP;
      end
      acc[comp_pos] = sum;

      // component fastest, then i, j, k
      comp_pos++;
      if (comp_pos >= cc) begin
        comp_pos = 0;
        pt_i++;
        if (pt_i > ord) begin
          pt_i = 0;
          pt_j++;
          if (pt_j > ord) begin
            pt_j = 0;
            pt_k++;
            if (pt_k > ord) pt_k = 0;
          end
        end
      end

      if (!is_last) return;
      for (int unsigned c = 0; c < cc; c++) begin
        a = acc[c];
        r = mul_round_sat(a[63] ? -a : a, vol_scale, gvqa_pkg::SCALE_SHIFT,
                          a[63] ? OUT_NEG_CAP : OUT_POS_CAP, hit);
        if (a[63]) r = -r;
        want.comp  = c[gvqa_pkg::COMP_OUT_W-1:0];
        want.value = r[gvqa_pkg::OUT_W-1:0];
        want.sat   = acc_sat[c] | hit;
        want.last  = (c + 1 == cc);
        pending_integrals.push_back(want);
        predicted++;
      end
      clear_run();
    endfunction

    // Result transfer: compare with the oldest prediction
    function void check_integral(logic [gvqa_pkg::COMP_OUT_W-1:0] ci,
                                 logic [gvqa_pkg::OUT_W-1:0] val, logic s, logic l);
      integral_t want;
      if (pending_integrals.size() == 0) begin
        $display("%0t: result for component %0d (value %h) with none expected",
                 $time, ci, val);
        errors++;
        return;
      end
      want = pending_integrals.pop_front();
      checked++;
      if (want.sat) saw_sat++;
      if (ci !== want.comp) begin
        $display("%0t: comp_index expected %0d, actual %0d", $time, want.comp, ci);
        errors++;
      end
      if (val !== want.value) begin
        $display("%0t: integral_value (comp %0d) expected %0d, actual %0d", $time,
                 want.comp, $signed(want.value), $signed(val));
        errors++;
      end
      if (s !== want.sat) begin
        $display("%0t: saturated (comp %0d) expected %b, actual %b", $time, want.comp,
                 want.sat, s);
        errors++;
      end
      if (l !== want.last) begin
        $display("%0t: last_result (comp %0d) expected %b, actual %b", $time, want.comp,
                 want.last, l);
        errors++;
      end
    endfunction
  endclass

  // Clock, reset and block inputs
  logic                                 clk          = 1'b0;
  logic                                 rst          = 1'b1;
  logic                                 cfg_valid    = 1'b0;
  logic [gvqa_pkg::CFG_IDX_W-1:0]       cfg_index    = '0;
  logic [gvqa_pkg::CFG_DATA_W-1:0]      cfg_data     = '0;
  logic                                 sample_valid = 1'b0;
  logic signed [31:0]                   sample_value = '0;
  logic                                 last_sample  = 1'b0;
  logic                                 result_stall = 1'b0;
  logic                                 cfg_ready;
  logic                                 sample_stall;
  logic                                 result_valid;
  logic [gvqa_pkg::COMP_OUT_W-1:0]      comp_index;
  logic signed [gvqa_pkg::OUT_W-1:0]    integral_value;
  logic                                 saturated;
  logic                                 last_result;

  integral_scoreboard sb = new();

  bit          quiet;
  int unsigned cycle_count;
  int unsigned samples_sent;
  int unsigned runs_done;
  int unsigned settings_done;
  logic [3:0]  cur_order = gvqa_pkg::MIN_ORDER;
  logic [3:0]  cur_count = 4'd1;

  gll_volume_quadrature_accumulator dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample_value   (sample_value),
    .last_sample    (last_sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .comp_index     (comp_index),
    .integral_value (integral_value),
    .saturated      (saturated),
    .last_result    (last_result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending_integrals.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_integral(comp_index, integral_value, saturated, last_result);
  end

  // Receiver back-pressure in random bursts, none in the quiet tail
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  end

  // One register transfer; valid is left high for a following write
  task automatic cfg_write(logic [gvqa_pkg::CFG_IDX_W-1:0] idx,
                           logic [gvqa_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(logic [3:0] ord, logic [3:0] cnt, logic [31:0] scale,
                              bit poke_unused);
    cfg_write(gvqa_pkg::CFG_QUAD_ORDER, {28'd0, ord});
    cfg_write(gvqa_pkg::CFG_COMP_COUNT, {28'd0, cnt});
    cfg_write(gvqa_pkg::CFG_VOLUME_SCALE, scale);
    if (poke_unused) cfg_write(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    cur_order = ord;
    cur_count = cnt;
    settings_done++;
  endtask

  // Wait until every predicted integral has left and the pipeline has emptied
  task automatic settle();
    sample_valid <= 1'b0;
    while (sb.pending_integrals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] v, bit is_last);
    quiet = (samples_sent >= ITEM_TARGET - QUIET_TAIL);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_value <= v;
    last_sample  <= is_last;
    do @(posedge clk); while (sample_stall);
    sb.take_sample(v, is_last);
    samples_sent++;
    if (is_last) runs_done++;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return $urandom_range(0, 131071) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0001_0000;
      3:       return $urandom_range(0, 262143);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_run(int unsigned len);
    for (int unsigned n = 0; n < len; n++)
      send_sample(pick_sample(), n + 1 == len);
  endtask

  // Main sequence
  initial begin
    int unsigned ord, cnt, pts, len;
    bit          first;
    logic [3:0]  new_order, new_count;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: full-scale positive and negative single-sample runs
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b1);

    // Largest volume factor with full-scale negatives: output saturates low
    settle();
    program_regs(4'd2, 4'd1, 32'hFFFF_FFFF, 1'b1);
    for (int n = 0; n < 9; n++) send_sample(32'h8000_0000, n == 8);

    // Order above range, zero components, zero volume factor
    settle();
    program_regs(4'd15, 4'd0, 32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);

    // Order below range, too many components; run ends after two samples
    settle();
    program_regs(4'd1, 4'd9, 32'h0001_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(pick_sample(), 1'b1);

    // Registers shrunk in mid run: counters past the new bounds restart
    settle();
    program_regs(4'd4, 4'd2, pick_scale(), 1'b0);
    for (int n = 0; n < 7; n++) send_sample(pick_sample(), 1'b0);
    settle();
    program_regs(4'd2, 4'd1, 32'h0001_0000, 1'b1);
    send_sample(pick_sample(), 1'b1);

    // Random runs: mostly whole elements, some cut short, some noise
    first = 1'b1;
    while (samples_sent < ITEM_TARGET) begin
      if (first || $urandom_range(0, 2) == 0) begin
        settle();
        if ($urandom_range(0, 9) < 6) new_order = 4'd2;
        else if ($urandom_range(0, 3) == 0) new_order = 4'($urandom_range(0, 15));
        else new_order = 4'($urandom_range(3, 10));
        if ($urandom_range(0, 9) < 7) new_count = 4'($urandom_range(1, 3));
        else new_count = 4'($urandom_range(0, 15));
        program_regs(new_order, new_count, pick_scale(), $urandom_range(0, 3) == 0);
        first = 1'b0;
      end
      ord = 32'(cur_order);
      if (ord < gvqa_pkg::MIN_ORDER) ord = 32'(gvqa_pkg::MIN_ORDER);
      if (ord > gvqa_pkg::MAX_ORDER) ord = 32'(gvqa_pkg::MAX_ORDER);
      cnt = 32'(cur_count);
      if (cnt == 0) cnt = 1;
      if (cnt > 8) cnt = 8;
      pts = (ord + 1) * (ord + 1) * (ord + 1) * cnt;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if (2 * pts <= 130 && $urandom_range(0, 1) == 1) len = 2 * pts;
          else if (pts <= 130) len = pts;
          else len = $urandom_range(1, 60);
        end
        6, 7, 8: len = $urandom_range(1, 30);
        default: len = $urandom_range(1, 4);
      endcase
      send_run(len);
    end

    settle();
    $display("Covered %0d samples in %0d runs over %0d register settings;", samples_sent,
             runs_done, settings_done);
    $display("%0d integrals compared, %0d of them saturated.", sb.checked, sb.saw_sat);
    if (sb.errors == 0 && sb.pending_integrals.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
